FILE: hdl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  // Quotient bits per divide, remainder width and divisor width
  localparam int QUO_W = 17;
  localparam int REM_W = 25;
  localparam int DVS_W = 9;

  // Hue in 1/64 degree: a full circle and twice each sector offset
  localparam logic [QUO_W-1:0] HUE_FULL     = 17'd23040;
  localparam logic [15:0]      HUE_OFS2_RED = 16'd0;
  localparam logic [15:0]      HUE_OFS2_GRN = 16'd15360;
  localparam logic [15:0]      HUE_OFS2_BLU = 16'd30720;
  localparam logic [15:0]      HUE_OFS2_WRP = 16'd46080;
  // Twice one sixty-degree step of hue (1/64 degree) per unit difference over span
  localparam logic signed [25:0] HUE_SLOPE2 = 26'sd7680;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  brightness;
  } hsv_t;

  // One restoring-divide lane: running remainder, divisor, quotient so far
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Everything one pipeline cell hands to the next
  typedef struct packed {
    div_lane_t  sat;
    div_lane_t  hue;
    logic       sat_zero;
    logic       hue_zero;
    logic [7:0] brightness;
  } stage_t;

endpackage

FILE: hdl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front cell, divider chain, result formatting.
// Converts one 8-bit RGB pixel per clock, while out_ready holds, into hue (1/64 degree,
// rounded, wrapped at 360), saturation (span/max in 1/65536, rounded) and brightness (max
// channel). Throughput is one pixel per cycle unless the output stalls. The path from input
// transfer to output is registered in one front cell plus a chain of 17 divider cells,
// each producing one quotient bit of both divides.
// Every cell is elastic, so a stalled output only stops the cells behind a full cell, and
// the block keeps taking pixels until the chain fills.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsv_t   out_data
);

  logic             vld [QUO_W+1];
  logic             rdy [QUO_W+1];
  stage_t           dat [QUO_W+1];
  logic [QUO_W-1:0] hue_wrap;
  stage_t           last;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_data  (dat[0])
  );

  // Chain of cells, most significant quotient bit first
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    rgbhsv_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_data  (dat[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_data  (dat[k+1])
    );
  end

  assign last       = dat[QUO_W];
  assign out_valid  = vld[QUO_W];
  assign rdy[QUO_W] = out_ready;

  // Wrap a hue that rounds to a full circle, then drop greys and black
  assign hue_wrap = (last.hue.quo >= HUE_FULL) ? (last.hue.quo - HUE_FULL) : last.hue.quo;

  always_comb begin
    out_data.hue        = last.hue_zero ? 15'd0 : hue_wrap[14:0];
    out_data.saturation = last.sat_zero ? 17'd0 : last.sat.quo;
    out_data.brightness = last.brightness;
  end

endmodule

FILE: hdl/rgbhsv_front.sv
// Front cell: finds max, min and sector and forms both dividends.
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  pixel_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  logic               valid_r;
  stage_t             data_r;
  stage_t             data_nxt;
  logic [7:0]         hi;
  logic [7:0]         lo;
  logic [7:0]         span;
  logic               red_max;
  logic               grn_max;
  logic signed [8:0]  diff;
  logic [15:0]        ofs2;
  logic signed [25:0] hue_sum;

  // Pick max and min
  always_comb begin
    hi = (up_data.red > up_data.green) ? up_data.red : up_data.green;
    if (up_data.blue > hi) begin
      hi = up_data.blue;
    end
    lo = (up_data.red < up_data.green) ? up_data.red : up_data.green;
    if (up_data.blue < lo) begin
      lo = up_data.blue;
    end
    span = hi - lo;
  end

  // Choose sector, red wins ties over green, green over blue
  always_comb begin
    red_max = (up_data.red >= up_data.green) && (up_data.red >= up_data.blue);
    grn_max = !red_max && (up_data.green >= up_data.blue);
    if (red_max) begin
      diff = $signed({1'b0, up_data.green}) - $signed({1'b0, up_data.blue});
      ofs2 = (up_data.green < up_data.blue) ? HUE_OFS2_WRP : HUE_OFS2_RED;
    end else if (grn_max) begin
      diff = $signed({1'b0, up_data.blue}) - $signed({1'b0, up_data.red});
      ofs2 = HUE_OFS2_GRN;
    end else begin
      diff = $signed({1'b0, up_data.red}) - $signed({1'b0, up_data.green});
      ofs2 = HUE_OFS2_BLU;
    end
  end

  // Hue dividend 2N + span is never negative and fits the remainder width
  assign hue_sum = 26'(diff) * HUE_SLOPE2 + $signed(26'(ofs2 * span)) + $signed(26'(span));

  // Build the first stage
  always_comb begin
    data_nxt.sat.rem    = REM_W'({span, 17'd0}) + REM_W'(hi);
    data_nxt.sat.dvs    = {hi, 1'b0};
    data_nxt.sat.quo    = '0;
    data_nxt.hue.rem    = hue_sum[REM_W-1:0];
    data_nxt.hue.dvs    = {span, 1'b0};
    data_nxt.hue.quo    = '0;
    data_nxt.sat_zero   = (hi == 8'd0);
    data_nxt.hue_zero   = (span == 8'd0);
    data_nxt.brightness = hi;
  end

  // Take a transfer when empty or when the next cell drains this one
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hdl/rgbhsv_div_cell.sv
// Divider cell: settles one quotient bit of both the saturation and hue divides.
module rgbhsv_div_cell
  import rgbhsv_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  // One restoring step on a lane against the divisor shifted to this bit
  function automatic div_lane_t div_step(input div_lane_t lane);
    div_lane_t        res;
    logic [REM_W-1:0] dvs_sh;
    dvs_sh = REM_W'(lane.dvs) << BIT;
    res    = lane;
    if (lane.rem >= dvs_sh) begin
      res.rem      = lane.rem - dvs_sh;
      res.quo[BIT] = 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    data_nxt     = up_data;
    data_nxt.sat = div_step(up_data.sat);
    data_nxt.hue = div_step(up_data.hue);
  end

  // Advance when empty or when the next cell drains this one
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
